// ===== design/drt2_pkg.sv =====
`timescale 1ns / 1ps

package drt2_pkg;

    localparam int MAX_RECTS_DEF = 16;

    localparam int COORD_W = 12;   // stored x / y
    localparam int DIM_W   = 13;   // stored w / h and screen size
    localparam int CFG_W   = 13;   // configuration data width

    localparam logic [DIM_W-1:0] SCREEN_MAX = 13'd4096;

    // request codes
    localparam logic [1:0] REQ_MARK     = 2'd0;
    localparam logic [1:0] REQ_MARK_ALL = 2'd1;
    localparam logic [1:0] REQ_PRESENT  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DISP_EN  = 2'd0;
    localparam logic [1:0] CFG_SCR_W    = 2'd1;
    localparam logic [1:0] CFG_SCR_H    = 2'd2;
    localparam logic [1:0] CFG_FLIP     = 2'd3;

    localparam logic             DISP_EN_RST = 1'b1;
    localparam logic [DIM_W-1:0] SCR_W_RST   = 13'd1024;
    localparam logic [DIM_W-1:0] SCR_H_RST   = 13'd768;
    localparam logic             FLIP_RST    = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
    } t_in_item;

    typedef struct packed {
        logic               has_rect;
        logic               dest_page;
        logic [COORD_W-1:0] copy_x;
        logic [COORD_W-1:0] copy_y;
        logic [DIM_W-1:0]   copy_w;
        logic [DIM_W-1:0]   copy_h;
        logic               whole_screen;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
    } t_rect;

    typedef enum logic [1:0] {
        SRC_ENTRY,
        SRC_WHOLE,
        SRC_ZERO
    } t_src;

    typedef struct packed {
        logic in_load;
        logic clamp_load;
        logic rd_en;
        logic wr_en;
        logic wr_merge;
        logic out_load;
        t_src out_src;
        logic out_page;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic rect_empty;
        logic hit;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== design/dirty_rect_tracker_two_page_core.sv =====
`timescale 1ns / 1ps
// Channel    Direction  Handshake                  Payload
// request    in         i_in_valid / o_in_stall    i_in_item  (t_in_item)
// result     out        o_out_valid / i_out_stall  o_out_item (t_out_item)
// config     in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Mark-all and ignored requests are handled in S_IDLE. A mark is clamped in S_IDLE, S_CLAMP and
// S_CHECK, then each page is visited in S_PAGE and scanned entry by entry in S_SCAN, bound by the single-port store.
// A present is accepted in S_IDLE, then each listed rectangle is read (S_PRD) and loaded into the output
// register (S_PEMIT); a whole-page or empty result goes straight to S_PEMIT, which waits while i_out_stall holds it.
// Reset (synchronous, active low) empties both lists and sets both full-page flags.

module dirty_rect_tracker_two_page_core import drt2_pkg::*; #(
    parameter int  MAX_RECTS = MAX_RECTS_DEF,
    localparam int IW        = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1,
    localparam int AW        = IW + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic             r_disp_en;
    logic [DIM_W-1:0] r_scr_w;
    logic [DIM_W-1:0] r_scr_h;
    logic             r_flip;

    t_dp_cmd       w_cmd;
    t_dp_sts       w_sts;
    logic [AW-1:0] w_mem_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_en <= DISP_EN_RST;
            r_scr_w   <= SCR_W_RST;
            r_scr_h   <= SCR_H_RST;
            r_flip    <= FLIP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DISP_EN: r_disp_en <= i_cfg_data[0];
                CFG_SCR_W:   r_scr_w   <= i_cfg_data[DIM_W-1:0];
                CFG_SCR_H:   r_scr_h   <= i_cfg_data[DIM_W-1:0];
                CFG_FLIP:    r_flip    <= i_cfg_data[0];
                default:     r_flip    <= r_flip;
            endcase
        end
    end

    drt2_ctrl #(
        .MAX_RECTS (MAX_RECTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_item.req_type),
        .i_disp_en  (r_disp_en),
        .i_flip     (r_flip),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .o_mem_addr (w_mem_addr),
        .i_sts      (w_sts)
    );

    drt2_dp #(
        .MAX_RECTS (MAX_RECTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_mem_addr  (w_mem_addr),
        .i_in_item   (i_in_item),
        .i_scr_w     (r_scr_w),
        .i_scr_h     (r_scr_h),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== design/drt2_dp.sv =====
`timescale 1ns / 1ps

module drt2_dp import drt2_pkg::*; #(
    parameter int  MAX_RECTS = MAX_RECTS_DEF,
    localparam int IW        = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1,
    localparam int AW        = IW + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [AW-1:0]    i_mem_addr,
    input  t_in_item         i_in_item,
    input  logic [DIM_W-1:0] i_scr_w,
    input  logic [DIM_W-1:0] i_scr_h,
    output t_dp_sts          o_sts,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    localparam int MEM_DEPTH = 2 * (1 << IW);
    localparam int CLW       = 18;          // room for sums of two 16-bit signed values
    localparam int EW        = DIM_W + 1;   // edge = coord + size

    // rectangle store, one half per page
    t_rect r_mem [MEM_DEPTH];
    t_rect r_rd_data;

    // first clamp stage (left/top edge)
    logic signed [CLW-1:0] r_xa, r_wa, r_ya, r_ha;
    logic                  r_neg;

    // clamped rectangle of the current mark
    t_rect r_rect;
    logic  r_empty;

    logic      r_out_valid;
    t_out_item r_out;

    logic [DIM_W-1:0]      w_sw, w_sh;
    logic signed [CLW-1:0] w_sw_s, w_sh_s;
    logic signed [CLW-1:0] w_x, w_y, w_w, w_h;
    logic signed [CLW-1:0] w_xend, w_yend, w_wf, w_hf;
    logic                  w_empty;

    logic [EW-1:0] w_ax, w_ay, w_bx, w_by;
    logic [EW-1:0] w_ax1, w_ay1, w_bx1, w_by1;
    logic [EW-1:0] w_mx0, w_my0, w_mx1, w_my1, w_mw, w_mh;
    logic          w_hit;
    t_rect         w_merged, w_wr_data;
    logic          w_out_free;
    t_out_item     w_out_next;

    // saturate screen size
    assign w_sw   = (i_scr_w > SCREEN_MAX) ? SCREEN_MAX : i_scr_w;
    assign w_sh   = (i_scr_h > SCREEN_MAX) ? SCREEN_MAX : i_scr_h;
    assign w_sw_s = CLW'(w_sw);
    assign w_sh_s = CLW'(w_sh);

    assign w_x = CLW'(i_in_item.rect_x);
    assign w_y = CLW'(i_in_item.rect_y);
    assign w_w = CLW'(i_in_item.rect_w);
    assign w_h = CLW'(i_in_item.rect_h);

    // second clamp stage (right/bottom edge)
    assign w_xend  = r_xa + r_wa;
    assign w_yend  = r_ya + r_ha;
    assign w_wf    = (w_xend > w_sw_s) ? (w_sw_s - r_xa) : r_wa;
    assign w_hf    = (w_yend > w_sh_s) ? (w_sh_s - r_ya) : r_ha;
    assign w_empty = r_neg || (w_wf <= 0) || (w_hf <= 0);

    // overlap-or-touch test and bounding union against the stored entry
    assign w_ax  = EW'(r_rd_data.x);
    assign w_ay  = EW'(r_rd_data.y);
    assign w_bx  = EW'(r_rect.x);
    assign w_by  = EW'(r_rect.y);
    assign w_ax1 = w_ax + EW'(r_rd_data.w);
    assign w_ay1 = w_ay + EW'(r_rd_data.h);
    assign w_bx1 = w_bx + EW'(r_rect.w);
    assign w_by1 = w_by + EW'(r_rect.h);

    assign w_hit = !((w_ax1 < w_bx) || (w_bx1 < w_ax) || (w_ay1 < w_by) || (w_by1 < w_ay));

    assign w_mx0 = (w_ax < w_bx) ? w_ax : w_bx;
    assign w_my0 = (w_ay < w_by) ? w_ay : w_by;
    assign w_mx1 = (w_ax1 > w_bx1) ? w_ax1 : w_bx1;
    assign w_my1 = (w_ay1 > w_by1) ? w_ay1 : w_by1;
    assign w_mw  = w_mx1 - w_mx0;
    assign w_mh  = w_my1 - w_my0;

    assign w_merged.x = w_mx0[COORD_W-1:0];
    assign w_merged.y = w_my0[COORD_W-1:0];
    assign w_merged.w = w_mw[DIM_W-1:0];
    assign w_merged.h = w_mh[DIM_W-1:0];

    assign w_wr_data = i_cmd.wr_merge ? w_merged : r_rect;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_mem_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_xa  <= (w_x < 0) ? '0 : w_x;
            r_wa  <= (w_x < 0) ? (w_w + w_x) : w_w;
            r_ya  <= (w_y < 0) ? '0 : w_y;
            r_ha  <= (w_y < 0) ? (w_h + w_y) : w_h;
            r_neg <= (w_w <= 0) || (w_h <= 0);
        end
        if (i_cmd.clamp_load) begin
            r_rect.x <= r_xa[COORD_W-1:0];
            r_rect.y <= r_ya[COORD_W-1:0];
            r_rect.w <= w_wf[DIM_W-1:0];
            r_rect.h <= w_hf[DIM_W-1:0];
            r_empty  <= w_empty;
        end
    end

    always_comb begin
        w_out_next              = '0;
        w_out_next.dest_page    = i_cmd.out_page;
        w_out_next.last         = i_cmd.out_last;
        case (i_cmd.out_src)
            SRC_ENTRY: begin
                w_out_next.has_rect = 1'b1;
                w_out_next.copy_x   = r_rd_data.x;
                w_out_next.copy_y   = r_rd_data.y;
                w_out_next.copy_w   = r_rd_data.w;
                w_out_next.copy_h   = r_rd_data.h;
            end
            SRC_WHOLE: begin
                w_out_next.has_rect     = 1'b1;
                w_out_next.copy_w       = w_sw;
                w_out_next.copy_h       = w_sh;
                w_out_next.whole_screen = 1'b1;
            end
            default: begin
                w_out_next.has_rect = 1'b0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    // output register: parts the sequencer from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out <= w_out_next;
        end
    end

    assign o_sts.rect_empty = r_empty;
    assign o_sts.hit        = w_hit;
    assign o_sts.out_free   = w_out_free;
    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out;

endmodule

// ===== design/drt2_ctrl.sv =====
`timescale 1ns / 1ps

module drt2_ctrl import drt2_pkg::*; #(
    parameter int  MAX_RECTS = MAX_RECTS_DEF,
    localparam int IW        = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1,
    localparam int CW        = $clog2(MAX_RECTS + 1),
    localparam int AW        = IW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_req_type,
    input  logic          i_disp_en,
    input  logic          i_flip,
    output logic          o_in_stall,
    output t_dp_cmd       o_cmd,
    output logic [AW-1:0] o_mem_addr,
    input  t_dp_sts       i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_CHECK,
        S_PAGE,
        S_SCAN,
        S_PRD,
        S_PEMIT
    } t_state;

    t_state          r_state, n_state;
    logic            r_page, n_page;       // page being updated by a mark
    logic            r_tp, n_tp;           // target page of a present
    t_src            r_src, n_src;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_count [2];
    logic [CW-1:0]   n_count [2];
    logic [1:0]      r_full, n_full;
    logic            r_shown, n_shown;

    logic            w_tp;
    logic [CW-1:0]   w_prev;
    logic            w_last;

    assign w_tp   = i_flip ? ~r_shown : 1'b0;
    assign w_prev = r_idx - CW'(1);
    assign w_last = (r_src != SRC_ENTRY) || ((r_idx + CW'(1)) == r_count[r_tp]);

    always_comb begin
        n_state    = r_state;
        n_page     = r_page;
        n_tp       = r_tp;
        n_src      = r_src;
        n_idx      = r_idx;
        n_count    = r_count;
        n_full     = r_full;
        n_shown    = r_shown;
        o_cmd      = '0;
        o_mem_addr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_MARK_ALL) begin
                        n_full     = 2'b11;
                        n_count[0] = '0;
                        n_count[1] = '0;
                    end else if (i_disp_en) begin
                        if (i_req_type == REQ_MARK) begin
                            o_cmd.in_load = 1'b1;
                            n_state       = S_CLAMP;
                        end else if (i_req_type == REQ_PRESENT) begin
                            n_tp  = w_tp;
                            n_idx = '0;
                            if (r_full[w_tp]) begin
                                n_src   = SRC_WHOLE;
                                n_state = S_PEMIT;
                            end else if (r_count[w_tp] == '0) begin
                                n_src   = SRC_ZERO;
                                n_state = S_PEMIT;
                            end else begin
                                n_src   = SRC_ENTRY;
                                n_state = S_PRD;
                            end
                        end
                    end
                end
            end

            S_CLAMP: begin
                o_cmd.clamp_load = 1'b1;
                n_state          = S_CHECK;
            end

            S_CHECK: begin
                n_page  = 1'b0;
                n_state = i_sts.rect_empty ? S_IDLE : S_PAGE;
            end

            S_PAGE: begin
                if (r_full[r_page]) begin
                    n_page  = 1'b1;
                    n_state = r_page ? S_IDLE : S_PAGE;
                end else if (r_count[r_page] == '0) begin
                    // empty list: append at slot zero
                    o_cmd.wr_en     = 1'b1;
                    o_mem_addr      = {r_page, IW'(0)};
                    n_count[r_page] = CW'(1);
                    n_page          = 1'b1;
                    n_state         = r_page ? S_IDLE : S_PAGE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_mem_addr  = {r_page, IW'(0)};
                    n_idx       = CW'(1);
                    n_state     = S_SCAN;
                end
            end

            // read data holds entry r_idx-1; the next read overlaps the compare
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_merge = 1'b1;
                    o_mem_addr     = {r_page, w_prev[IW-1:0]};
                    n_page         = 1'b1;
                    n_state        = r_page ? S_IDLE : S_PAGE;
                end else if (r_idx == r_count[r_page]) begin
                    if (r_count[r_page] == CW'(MAX_RECTS)) begin
                        // overflow: fall back to a full-page copy
                        n_full[r_page]  = 1'b1;
                        n_count[r_page] = '0;
                    end else begin
                        o_cmd.wr_en     = 1'b1;
                        o_mem_addr      = {r_page, r_count[r_page][IW-1:0]};
                        n_count[r_page] = r_count[r_page] + CW'(1);
                    end
                    n_page  = 1'b1;
                    n_state = r_page ? S_IDLE : S_PAGE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_mem_addr  = {r_page, r_idx[IW-1:0]};
                    n_idx       = r_idx + CW'(1);
                end
            end

            S_PRD: begin
                o_cmd.rd_en = 1'b1;
                o_mem_addr  = {r_tp, r_idx[IW-1:0]};
                n_state     = S_PEMIT;
            end

            S_PEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = r_src;
                    o_cmd.out_page = r_tp;
                    o_cmd.out_last = w_last;
                    if (w_last) begin
                        n_full[r_tp]  = 1'b0;
                        n_count[r_tp] = '0;
                        if (i_flip) begin
                            n_shown = r_tp;
                        end
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_PRD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_page     <= 1'b0;
            r_tp       <= 1'b0;
            r_src      <= SRC_ZERO;
            r_idx      <= '0;
            r_count[0] <= '0;
            r_count[1] <= '0;
            r_full     <= 2'b11;
            r_shown    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_page     <= n_page;
            r_tp       <= n_tp;
            r_src      <= n_src;
            r_idx      <= n_idx;
            r_count[0] <= n_count[0];
            r_count[1] <= n_count[1];
            r_full     <= n_full;
            r_shown    <= n_shown;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
